### rtl/core/scfe_pkg.sv
// Shared types and constants for the second-chance FIFO eviction block.
package scfe_pkg;

  localparam int IdW = 64;
  localparam int CapW = 7;
  localparam logic [CapW-1:0] CapReset = 7'd64;
  localparam logic MODE_ACCESS = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef struct packed {
    logic           mode;
    logic [IdW-1:0] object_id;
  } req_t;

  typedef struct packed {
    logic           hit;
    logic           evicted_valid;
    logic [IdW-1:0] evicted_id;
  } rsp_t;

endpackage

### rtl/core/scfe_ram.sv
// Single write port, single registered read port memory.
module scfe_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/scfe_ctrl.sv
// Sequencer: serial lookup scan, remove, second-chance walk, eviction and insert.
module scfe_ctrl import scfe_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [CapW-1:0] cap,
  input  logic            start,
  input  req_t            req,
  output logic            busy,
  output logic            done,
  output rsp_t            rsp
);

  localparam int SW = $clog2(CAPACITY);
  localparam int OW = $clog2(CAPACITY + 1);
  localparam int CW = (OW > CapW) ? OW : CapW;
  localparam logic [SW-1:0] LastSlot = SW'(CAPACITY - 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN     = 4'd1;
  localparam logic [3:0] S_SCAN_END = 4'd2;
  localparam logic [3:0] S_DISPATCH = 4'd3;
  localparam logic [3:0] S_EV_LOOP  = 4'd4;
  localparam logic [3:0] S_EV_CHECK = 4'd5;
  localparam logic [3:0] S_DET_RD   = 4'd6;
  localparam logic [3:0] S_DET_WR   = 4'd7;
  localparam logic [3:0] S_ATTACH   = 4'd8;
  localparam logic [3:0] S_INSERT   = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  localparam logic [1:0] CTX_REMOVE = 2'd0;
  localparam logic [1:0] CTX_WALK   = 2'd1;
  localparam logic [1:0] CTX_EVICT  = 2'd2;

  logic [3:0]          state;
  logic [1:0]          ctx;
  logic                mode;
  logic [IdW-1:0]      obj;
  logic [SW-1:0]       idx;
  logic                pend;
  logic                pend_v;
  logic [SW-1:0]       pend_idx;
  logic                found;
  logic [SW-1:0]       match;
  logic                free_found;
  logic [SW-1:0]       free;
  logic [SW-1:0]       s;
  logic [SW-1:0]       head;
  logic [SW-1:0]       tail;
  logic [OW-1:0]       occ;
  logic [CAPACITY-1:0] valid;
  logic [CAPACITY-1:0] marked;
  logic                ev_valid;
  logic [IdW-1:0]      ev_id;

  logic [SW-1:0]  id_raddr;
  logic [IdW-1:0] id_rdata;
  logic [SW-1:0]  nxt;
  logic [SW-1:0]  prv;
  logic           nl_we;
  logic [SW-1:0]  nl_waddr;
  logic [SW-1:0]  nl_wdata;
  logic           pl_we;
  logic [SW-1:0]  pl_waddr;
  logic [SW-1:0]  pl_wdata;
  logic           hit_now;
  logic [CW-1:0]  cap_ext;
  logic [CW-1:0]  eff_cap;
  logic [CW-1:0]  occ_ext;
  logic           must_evict;
  logic           middle;
  logic [SW-1:0]  att_slot;
  logic           att_empty;

  assign id_raddr = (state == S_SCAN) ? idx : s;
  assign hit_now = pend && pend_v && (id_rdata == obj);
  assign cap_ext = CW'(cap);
  assign occ_ext = CW'(occ);
  assign eff_cap = (cap_ext == '0) ? CW'(1) :
                   (cap_ext > CW'(CAPACITY)) ? CW'(CAPACITY) : cap_ext;
  assign must_evict = (occ_ext >= eff_cap) && (occ != '0);
  assign middle = (occ > OW'(1)) && (s != head) && (s != tail);
  assign att_slot = (state == S_INSERT) ? free : s;
  assign att_empty = (state == S_INSERT) ? (occ == '0) : (occ == OW'(1));

  scfe_ram #(.WIDTH(IdW), .DEPTH(CAPACITY)) u_ids (
    .clk(clk), .we(state == S_INSERT), .waddr(free), .wdata(obj),
    .raddr(id_raddr), .rdata(id_rdata)
  );

  scfe_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_next (
    .clk(clk), .we(nl_we), .waddr(nl_waddr), .wdata(nl_wdata),
    .raddr(s), .rdata(nxt)
  );

  scfe_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_prev (
    .clk(clk), .we(pl_we), .waddr(pl_waddr), .wdata(pl_wdata),
    .raddr(s), .rdata(prv)
  );

  always_comb begin
    nl_we = 1'b0;
    nl_waddr = att_slot;
    nl_wdata = head;
    pl_we = 1'b0;
    pl_waddr = head;
    pl_wdata = att_slot;
    if (state == S_DET_WR && middle) begin
      nl_we = 1'b1;
      nl_waddr = prv;
      nl_wdata = nxt;
      pl_we = 1'b1;
      pl_waddr = nxt;
      pl_wdata = prv;
    end else if ((state == S_ATTACH || state == S_INSERT) && !att_empty) begin
      nl_we = 1'b1;
      pl_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      marked <= '0;
      head <= '0;
      tail <= '0;
      occ <= '0;
      pend <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            mode <= req.mode;
            obj <= req.object_id;
            idx <= '0;
            pend <= 1'b0;
            found <= 1'b0;
            free_found <= 1'b0;
            ev_valid <= 1'b0;
            ev_id <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN, S_SCAN_END: begin
          if (hit_now) begin
            found <= 1'b1;
            match <= pend_idx;
          end
          if (state == S_SCAN) begin
            pend <= 1'b1;
            pend_v <= valid[idx];
            pend_idx <= idx;
            if (!valid[idx] && !free_found) begin
              free_found <= 1'b1;
              free <= idx;
            end
            if (idx == LastSlot) begin
              state <= S_SCAN_END;
            end else begin
              idx <= idx + SW'(1);
            end
          end else begin
            pend <= 1'b0;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          if (found && mode == MODE_REMOVE) begin
            s <= match;
            ctx <= CTX_REMOVE;
            state <= S_DET_RD;
          end else if (found) begin
            marked[match] <= 1'b1;
            state <= S_DONE;
          end else if (mode == MODE_REMOVE) begin
            state <= S_DONE;
          end else begin
            state <= S_EV_LOOP;
          end
        end
        S_EV_LOOP: begin
          if (must_evict) begin
            s <= tail;
            state <= S_EV_CHECK;
          end else if (free_found) begin
            state <= S_INSERT;
          end else begin
            state <= S_DONE;
          end
        end
        S_EV_CHECK: begin
          if (marked[s]) begin
            marked[s] <= 1'b0;
            if (s != head) begin
              ctx <= CTX_WALK;
              state <= S_DET_RD;
            end else begin
              state <= S_EV_LOOP;
            end
          end else begin
            ctx <= CTX_EVICT;
            state <= S_DET_RD;
          end
        end
        S_DET_RD: begin
          state <= S_DET_WR;
        end
        S_DET_WR: begin
          if (occ > OW'(1)) begin
            if (s == head) begin
              head <= nxt;
            end else if (s == tail) begin
              tail <= prv;
            end
          end
          unique case (ctx)
            CTX_WALK: state <= S_ATTACH;
            CTX_EVICT: begin
              valid[s] <= 1'b0;
              marked[s] <= 1'b0;
              occ <= occ - OW'(1);
              if (!ev_valid) begin
                ev_valid <= 1'b1;
                ev_id <= id_rdata;
              end
              if (!free_found || s < free) begin
                free_found <= 1'b1;
                free <= s;
              end
              state <= S_EV_LOOP;
            end
            default: begin
              valid[s] <= 1'b0;
              marked[s] <= 1'b0;
              occ <= occ - OW'(1);
              state <= S_DONE;
            end
          endcase
        end
        S_ATTACH, S_INSERT: begin
          if (att_empty) begin
            tail <= att_slot;
          end
          head <= att_slot;
          if (state == S_INSERT) begin
            valid[free] <= 1'b1;
            marked[free] <= 1'b0;
            occ <= occ + OW'(1);
            state <= S_DONE;
          end else begin
            state <= S_EV_LOOP;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);
  assign rsp.hit = found;
  assign rsp.evicted_valid = ev_valid;
  assign rsp.evicted_id = ev_id;

endmodule

### rtl/core/second_chance_fifo_eviction_top.sv
// Top level: configuration register, APB port and the eviction sequencer.
// Every request starts with a serial lookup scan of all slots; a hit or a remove miss then
// finishes. A remove hit detaches the entry. An access miss evicts unmarked tail entries,
// moves marked ones to the head, clearing the mark, then inserts the new object. Reset
// clears all entries and sets capacity to 64. Throughput: one item at a time; busy holds
// until the done cycle. The receiver cannot stall: done shows for one cycle.
module second_chance_fifo_eviction_top import scfe_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  req_t        req,
  output logic        busy,
  output logic        done,
  output rsp_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] REG_CAPACITY = 3'd0;

  logic [CapW-1:0] cap;
  logic            sel;

  assign pready = 1'b1;
  assign sel = (paddr == REG_CAPACITY);
  assign prdata = sel ? {25'd0, cap} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CapReset;
    end else if (psel && penable && pwrite && pready && sel) begin
      cap <= pwdata[CapW-1:0];
    end
  end

  scfe_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk(clk), .rst(rst), .cap(cap), .start(start), .req(req),
    .busy(busy), .done(done), .rsp(rsp)
  );

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held");
  a_evict_miss: assert property (@(posedge clk) disable iff (rst)
    done && rsp.evicted_valid |-> !rsp.hit)
    else $error("eviction on hit");
  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    done && !rsp.evicted_valid |-> rsp.evicted_id == '0)
    else $error("stale evicted id");
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("transfer not taken");

endmodule
